// ===== hw/rtl/mean_flow_keyframe_gate_core_assert.svh =====
`ifndef MEAN_FLOW_KEYFRAME_GATE_CORE_ASSERT_SVH
`define MEAN_FLOW_KEYFRAME_GATE_CORE_ASSERT_SVH

// same-cycle implication on aclk, off during reset
`define MFKG_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off during reset
`define MFKG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/mfkg_pkg.sv =====
package mfkg_pkg;

    localparam int COORD_IN_W    = 16;
    localparam int MIN_FLOW_W    = 16;
    localparam int FLOW_SUM_W    = 29;
    localparam int MEAN_W        = 17;
    localparam int MATCH_COUNT_W = 13;
    localparam int STATUS_W      = 3;

    localparam logic KIND_MEAS = 1'b0;
    localparam logic KIND_END  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_NO_REF    = 3'd0,
        STATUS_NO_MEAS   = 3'd1,
        STATUS_NO_MATCH  = 3'd2,
        STATUS_LOW_FLOW  = 3'd3,
        STATUS_HIGH_FLOW = 3'd4
    } status_t;

    typedef struct packed {
        logic                  kind;
        logic [COORD_IN_W-1:0] new_x;
        logic [COORD_IN_W-1:0] new_y;
        logic [COORD_IN_W-1:0] last_x;
        logic [COORD_IN_W-1:0] last_y;
        logic                  matched;
        logic                  has_reference;
    } in_item_t;

    typedef struct packed {
        logic                     usable;
        logic [STATUS_W-1:0]      status;
        logic [MEAN_W-1:0]        mean_flow;
        logic [MATCH_COUNT_W-1:0] match_count;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ_X,
        ST_SQ_Y,
        ST_ROOT_GO,
        ST_ROOT,
        ST_THRESH,
        ST_DIVIDE,
        ST_RESULT
    } fsm_state_t;

endpackage

// ===== hw/rtl/mfkg_sqrt.sv =====
module mfkg_sqrt #(
    parameter int OP_W = 34
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [OP_W-1:0]         operand,
    output mfkg_pkg::unit_stat_t    stat,
    output logic [OP_W/2-1:0]       root
);
    import mfkg_pkg::*;

    localparam int ROOT_W = OP_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W);

    logic [OP_W-1:0]   op_reg, op_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+2:0]  trial;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
    end

    always_comb begin
        rem_sh    = {rem_reg, op_reg[OP_W-1 -: 2]};
        trial     = {1'b0, rem_sh} - (REM_W+3)'({root_reg, 2'b01});
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            op_next   = operand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            op_next = {op_reg[OP_W-3:0], 2'b00};
            if (!trial[REM_W+2]) begin
                rem_next  = trial[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;

endmodule

// ===== hw/rtl/mfkg_div.sv =====
module mfkg_div #(
    parameter int NUM_W = 29,
    parameter int DEN_W = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [NUM_W-1:0]     dividend,
    input  logic [DEN_W-1:0]     divisor,
    output mfkg_pkg::unit_stat_t stat,
    output logic [NUM_W-1:0]     quotient
);
    import mfkg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = {1'b0, shifted} - (DEN_W+2)'(den_reg);
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = CNT_W'(NUM_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DEN_W+1]) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ===== hw/rtl/mean_flow_keyframe_gate_core.sv =====
// Keyframe gate on mean optical flow. Send each feature measurement of a frame as a request
// with kind = 0, then one request with kind = 1 to close the frame; only the closing request
// returns a result. An unmatched measurement ends in its accepting cycle. A matched one
// passes through the accepting cycle, the two squares on one shared multiplier for the squared
// distance, a start step, the bit-serial square root with one result bit per cycle, and a
// step to fold the root into the sum. A closing request passes through the accepting cycle,
// a step that forms min_flow times the count and starts the restoring divider (one quotient
// bit per cycle) that forms the mean, a step that sees it finish and one that loads the
// output register, held longer while an earlier decision still sits there untaken. The
// output register lets the next frame's measurements enter while a decision waits to be
// taken. There is no clearing pass after reset. min_flow may be written whenever no request
// is in flight.
module mean_flow_keyframe_gate_core #(
    parameter int MAX_MATCHES = 4096,
    parameter int COORD_WIDTH = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  mfkg_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mfkg_pkg::out_item_t m_data
);
    import mfkg_pkg::*;

    localparam int CW      = (COORD_WIDTH < COORD_IN_W) ? COORD_WIDTH : COORD_IN_W;
    localparam int CNT_W   = $clog2(MAX_MATCHES + 1);
    localparam int MUL_A_W = (CW > CNT_W) ? CW : CNT_W;
    localparam int PROD_W  = MUL_A_W + MIN_FLOW_W;
    localparam int ACC_W   = PROD_W + 2;
    localparam int SQ_W    = 2 * CW + 2;
    localparam int ROOT_W  = CW + 1;

    fsm_state_t              state_reg, state_next;
    logic [MIN_FLOW_W-1:0]   min_flow_reg, min_flow_next;
    logic [FLOW_SUM_W-1:0]   flow_sum_reg, flow_sum_next;
    logic [CNT_W-1:0]        pair_count_reg, pair_count_next;
    logic                    any_meas_reg, any_meas_next;
    logic                    has_ref_reg, has_ref_next;
    logic [CW-1:0]           dx_reg, dx_next;
    logic [CW-1:0]           dy_reg, dy_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_data_reg, m_data_next;

    logic [MUL_A_W-1:0]      mul_a;
    logic [MIN_FLOW_W-1:0]   mul_b;
    logic [PROD_W-1:0]       product;
    logic [CW-1:0]           new_x_c, new_y_c, last_x_c, last_y_c;
    logic [FLOW_SUM_W:0]     sum_add;
    logic                    accept, out_free;
    logic                    sqrt_start, div_start;
    unit_stat_t              sqrt_stat, div_stat;
    logic [ROOT_W-1:0]       root;
    logic [FLOW_SUM_W-1:0]   quotient;

    mfkg_sqrt #(
        .OP_W(SQ_W)
    ) u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .operand  (acc_reg[SQ_W-1:0]),
        .stat     (sqrt_stat),
        .root     (root)
    );

    mfkg_div #(
        .NUM_W(FLOW_SUM_W),
        .DEN_W(CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (flow_sum_reg),
        .divisor  (pair_count_reg),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            min_flow_reg   <= '0;
            flow_sum_reg   <= '0;
            pair_count_reg <= '0;
            any_meas_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            min_flow_reg   <= min_flow_next;
            flow_sum_reg   <= flow_sum_next;
            pair_count_reg <= pair_count_next;
            any_meas_reg   <= any_meas_next;
            m_valid_reg    <= m_valid_next;
        end
        has_ref_reg <= has_ref_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        acc_reg     <= acc_next;
        m_data_reg  <= m_data_next;
    end

    assign new_x_c  = s_data.new_x[CW-1:0];
    assign new_y_c  = s_data.new_y[CW-1:0];
    assign last_x_c = s_data.last_x[CW-1:0];
    assign last_y_c = s_data.last_y[CW-1:0];
    assign product  = mul_a * mul_b;
    assign sum_add  = {1'b0, flow_sum_reg} + (FLOW_SUM_W+1)'(root);
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        min_flow_next   = cfg_wr_en ? cfg_wr_data : min_flow_reg;
        flow_sum_next   = flow_sum_reg;
        pair_count_next = pair_count_reg;
        any_meas_next   = any_meas_reg;
        has_ref_next    = has_ref_reg;
        dx_next         = dx_reg;
        dy_next         = dy_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        mul_a           = MUL_A_W'(dx_reg);
        mul_b           = MIN_FLOW_W'(dx_reg);
        sqrt_start      = 1'b0;
        div_start       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.kind == KIND_MEAS) begin
                        any_meas_next = 1'b1;
                        dx_next = (new_x_c >= last_x_c) ? new_x_c - last_x_c
                                                        : last_x_c - new_x_c;
                        dy_next = (new_y_c >= last_y_c) ? new_y_c - last_y_c
                                                        : last_y_c - new_y_c;
                        if (s_data.matched) begin
                            state_next = ST_SQ_X;
                        end
                    end else begin
                        has_ref_next = s_data.has_reference;
                        state_next   = ST_THRESH;
                    end
                end
            end
            ST_SQ_X: begin
                acc_next   = ACC_W'(product);
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y: begin
                mul_a      = MUL_A_W'(dy_reg);
                mul_b      = MIN_FLOW_W'(dy_reg);
                acc_next   = acc_reg + ACC_W'(product);
                state_next = ST_ROOT_GO;
            end
            ST_ROOT_GO: begin
                sqrt_start = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sqrt_stat.done) begin
                    flow_sum_next = sum_add[FLOW_SUM_W] ? '1 : sum_add[FLOW_SUM_W-1:0];
                    if (pair_count_reg != CNT_W'(MAX_MATCHES)) begin
                        pair_count_next = pair_count_reg + 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_THRESH: begin
                mul_a      = MUL_A_W'(pair_count_reg);
                mul_b      = min_flow_reg;
                acc_next   = ACC_W'(product);
                div_start  = 1'b1;
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_stat.done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next            = 1'b1;
                    m_data_next.match_count = MATCH_COUNT_W'(pair_count_reg);
                    m_data_next.mean_flow   = (pair_count_reg == '0) ? '0
                                                                      : MEAN_W'(quotient);
                    if (!has_ref_reg) begin
                        m_data_next.usable = 1'b1;
                        m_data_next.status = STATUS_NO_REF;
                    end else if (!any_meas_reg) begin
                        m_data_next.usable = 1'b0;
                        m_data_next.status = STATUS_NO_MEAS;
                    end else if (pair_count_reg == '0) begin
                        m_data_next.usable = 1'b0;
                        m_data_next.status = STATUS_NO_MATCH;
                    end else if (ACC_W'(flow_sum_reg) > acc_reg) begin
                        m_data_next.usable = 1'b1;
                        m_data_next.status = STATUS_HIGH_FLOW;
                    end else begin
                        m_data_next.usable = 1'b0;
                        m_data_next.status = STATUS_LOW_FLOW;
                    end
                    flow_sum_next   = '0;
                    pair_count_next = '0;
                    any_meas_next   = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`include "mean_flow_keyframe_gate_core_assert.svh"

    `MFKG_ASSERT_SAME(a_sqrt_in_root, (sqrt_stat.busy || sqrt_stat.done),
        (state_reg == ST_ROOT), "square root unit active outside root state")
    `MFKG_ASSERT_SAME(a_div_in_divide, (div_stat.busy || div_stat.done),
        (state_reg == ST_DIVIDE), "divider active outside divide state")
    `MFKG_ASSERT_SAME(a_count_bound, 1'b1,
        (pair_count_reg <= CNT_W'(MAX_MATCHES)), "pair count above saturation limit")
    `MFKG_ASSERT_SAME(a_result_source, $rose(m_valid_reg),
        ($past(state_reg) == ST_RESULT), "result raised outside result state")
    `MFKG_ASSERT_NEXT(a_clear_after_end, (state_reg == ST_RESULT && out_free),
        (pair_count_reg == '0 && flow_sum_reg == '0 && !any_meas_reg),
        "frame state not cleared after decision")

endmodule

// ===== verif/mean_flow_keyframe_gate_tb.sv =====
`timescale 1ns / 1ps

module testbench;
    import mfkg_pkg::*;

    localparam int unsigned    CYCLE_LIMIT    = 300000;
    localparam int unsigned    SETTLE_CYCLES  = 48;
    localparam int unsigned    HOLD_CYCLES    = 600;
    localparam int unsigned    PAIR_LIMIT     = 4096;
    localparam longint unsigned FLOW_SUM_LIMIT = (64'd1 << FLOW_SUM_W) - 1;
    localparam int unsigned    LONG_PAIRS     = 20;

    class flow_gate_scoreboard;
        logic [MIN_FLOW_W-1:0]    threshold;
        logic [FLOW_SUM_W-1:0]    flow_total;
        logic [MATCH_COUNT_W-1:0] pairs;
        bit                       saw_measurement;
        out_item_t                pending_decisions[$];
        int unsigned              errors;

        function new();
            threshold       = '0;
            flow_total      = '0;
            pairs           = '0;
            saw_measurement = 1'b0;
            errors          = 0;
        endfunction

        function void set_threshold(logic [MIN_FLOW_W-1:0] value);
            threshold = value;
        endfunction

        function int pending();
            return pending_decisions.size();
        endfunction

        // floor square root, one result bit per pair of operand bits
        function longint unsigned floor_root(longint unsigned value);
            longint unsigned root;
            longint unsigned rest;
            longint unsigned trial;
            root = 0;
            rest = 0;
            for (int i = 16; i >= 0; i--) begin
                rest  = (rest << 2) | ((value >> (2 * i)) & 64'd3);
                trial = (root << 2) | 64'd1;
                if (rest >= trial) begin
                    rest = rest - trial;
                    root = (root << 1) | 64'd1;
                end else begin
                    root = root << 1;
                end
            end
            return root;
        endfunction

        function void note_request(in_item_t req);
            longint unsigned dx;
            longint unsigned dy;
            longint unsigned total;
            out_item_t       d;
            if (req.kind == KIND_MEAS) begin
                saw_measurement = 1'b1;
                if (req.matched) begin
                    dx = (req.new_x >= req.last_x) ? 64'(req.new_x) - 64'(req.last_x)
                                                   : 64'(req.last_x) - 64'(req.new_x);
                    dy = (req.new_y >= req.last_y) ? 64'(req.new_y) - 64'(req.last_y)
                                                   : 64'(req.last_y) - 64'(req.new_y);
                    total = 64'(flow_total) + floor_root(dx * dx + dy * dy);
                    flow_total = (total > FLOW_SUM_LIMIT) ? FLOW_SUM_LIMIT[FLOW_SUM_W-1:0]
                                                          : total[FLOW_SUM_W-1:0];
                    if (pairs < PAIR_LIMIT)
                        pairs = pairs + 1'b1;
                end
            end else begin
                d.mean_flow   = (pairs != 0) ? MEAN_W'(64'(flow_total) / 64'(pairs)) : '0;
                d.match_count = pairs;
                if (!req.has_reference) begin
                    d.usable = 1'b1;
                    d.status = STATUS_NO_REF;
                end else if (!saw_measurement) begin
                    d.usable = 1'b0;
                    d.status = STATUS_NO_MEAS;
                end else if (pairs == 0) begin
                    d.usable = 1'b0;
                    d.status = STATUS_NO_MATCH;
                end else if (64'(flow_total) > 64'(threshold) * 64'(pairs)) begin
                    d.usable = 1'b1;
                    d.status = STATUS_HIGH_FLOW;
                end else begin
                    d.usable = 1'b0;
                    d.status = STATUS_LOW_FLOW;
                end
                pending_decisions = {pending_decisions, d};
                flow_total      = '0;
                pairs           = '0;
                saw_measurement = 1'b0;
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", what);
        endtask

        task check_result(out_item_t got);
            out_item_t want;
            if (pending_decisions.size() == 0) begin
                report($sformatf("decision with none pending: usable %b status %0d",
                                 got.usable, got.status));
            end else begin
                want = pending_decisions.pop_front();
                if (got.usable !== want.usable)
                    report($sformatf("usable %b, want %b", got.usable, want.usable));
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.mean_flow !== want.mean_flow)
                    report($sformatf("mean_flow %0d, want %0d", got.mean_flow, want.mean_flow));
                if (got.match_count !== want.match_count)
                    report($sformatf("match_count %0d, want %0d",
                                     got.match_count, want.match_count));
            end
        endtask
    endclass

    logic      aclk;
    logic      aresetn;
    logic      cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    flow_gate_scoreboard sb;
    bit          gaps_on;
    bit          stalls_on;
    bit          hold_wanted = 1'b0;
    bit          hold_taken  = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned cycles      = 0;

    mean_flow_keyframe_gate_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    always begin
        @(negedge aclk);
        if (hold_wanted && !hold_taken) begin
            hold_left  = HOLD_CYCLES;
            hold_taken = 1'b1;
        end
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else begin
            m_ready <= stalls_on ? ($urandom_range(0, 99) >= 18) : 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    task automatic send(in_item_t req);
        @(negedge aclk);
        while (gaps_on && $urandom_range(0, 99) < 18) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(req);
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic reconfigure(logic [15:0] value);
        stop_sending();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= 16'($urandom);
        sb.set_threshold(value);
    endtask

    function automatic in_item_t measurement(logic [15:0] nx, logic [15:0] ny,
                                             logic [15:0] lx, logic [15:0] ly,
                                             logic matched);
        in_item_t r;
        r.kind          = KIND_MEAS;
        r.new_x         = nx;
        r.new_y         = ny;
        r.last_x        = lx;
        r.last_y        = ly;
        r.matched       = matched;
        r.has_reference = 1'($urandom);
        return r;
    endfunction

    function automatic in_item_t frame_end(logic has_ref);
        in_item_t r;
        r.kind          = KIND_END;
        r.new_x         = 16'($urandom);
        r.new_y         = 16'($urandom);
        r.last_x        = 16'($urandom);
        r.last_y        = 16'($urandom);
        r.matched       = 1'($urandom);
        r.has_reference = has_ref;
        return r;
    endfunction

    function automatic in_item_t random_measurement(int unsigned spread);
        in_item_t    r;
        int unsigned style;
        r = measurement(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                        $urandom_range(0, 99) < 80);
        style = $urandom_range(0, 9);
        if (style >= 4 && style <= 8) begin
            // displacement around the current threshold
            r.last_x = $urandom_range(0, 1) ? r.new_x + 16'($urandom_range(0, spread))
                                            : r.new_x - 16'($urandom_range(0, spread));
            r.last_y = $urandom_range(0, 1) ? r.new_y + 16'($urandom_range(0, spread))
                                            : r.new_y - 16'($urandom_range(0, spread));
        end else if (style == 9) begin
            r.new_x  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            r.new_y  = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            r.last_x = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            r.last_y = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return r;
    endfunction

    task automatic random_frames(int unsigned quota);
        int unsigned sent;
        int unsigned n;
        int unsigned spread;
        sent   = 0;
        spread = 32'(sb.threshold) * 3 / 2 + 16;
        if (spread > 65535)
            spread = 65535;
        while (sent < quota) begin
            n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
            repeat (n) send(random_measurement(spread));
            send(frame_end($urandom_range(0, 99) >= 12));
            sent += n + 1;
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        gaps_on     = 1'b1;
        stalls_on   = 1'b1;
        sb          = new();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // threshold at its reset value of zero
        send(frame_end(1'b1));
        send(frame_end(1'b0));
        send(measurement(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 1'b0));
        send(frame_end(1'b1));
        send(measurement(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send(frame_end(1'b1));
        send(measurement(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
        send(measurement(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
        send(measurement(16'hFFFF, 16'hFFFF, 16'($urandom), 16'($urandom), 1'b0));
        send(frame_end(1'b1));
        send(measurement(16'h0001, 16'h0001, 16'h0000, 16'h0000, 1'b1));
        send(measurement(16'h0010, 16'h0000, 16'h0000, 16'h0000, 1'b1));
        send(frame_end(1'b0));

        reconfigure(16'hFFFF);
        send(measurement(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 1'b1));
        send(frame_end(1'b1));
        // flow equal to the threshold must not pass
        send(measurement(16'hFFFF, 16'h1234, 16'h0000, 16'h1234, 1'b1));
        send(frame_end(1'b1));

        reconfigure(16'($urandom_range(0, 65535)));
        random_frames(80);
        stop_sending();
        drain();
        random_frames(20);

        reconfigure(16'd24);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        random_frames(70);
        stop_sending();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        reconfigure(16'd0);
        random_frames(70);

        // long result-side hold-off: the block must back up and stall requests
        reconfigure(16'd400);
        hold_wanted = 1'b1;
        repeat (6) begin
            send(random_measurement(600));
            send(frame_end(1'b1));
        end
        random_frames(60);

        reconfigure(16'hFFFF);
        random_frames(70);

        // one long frame of largest displacements
        for (int k = 0; k < LONG_PAIRS; k++) begin
            if (k[0])
                send(measurement(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
            else
                send(measurement(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b1));
        end
        send(frame_end(1'b1));

        stop_sending();
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end
endmodule
